// ===== src/sav_pkg.sv =====
package sav_pkg;

  localparam int TEMP_W  = 11;
  localparam int HUMID_W = 10;
  localparam int RAW_W   = 10;
  localparam int PCT_W   = 7;
  localparam int TONE_W  = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // raw * 100 / 1023
  localparam int PCT_SCALE  = 100;
  localparam int RAW_FULL   = 1023;
  localparam int SCALED_W   = 17;

  localparam logic [TONE_W-1:0] TONE_NONE       = 11'd0;
  localparam logic [TONE_W-1:0] TONE_TEMP       = 11'd1000;
  localparam logic [TONE_W-1:0] TONE_HUMID      = 11'd800;
  localparam logic [TONE_W-1:0] TONE_LIGHT_LOW  = 11'd600;
  localparam logic [TONE_W-1:0] TONE_LIGHT_HIGH = 11'd1200;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 11'sd60;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 11'sd200;
  localparam logic [HUMID_W-1:0]       HUMID_LOW_RST  = 10'd600;
  localparam logic [HUMID_W-1:0]       HUMID_HIGH_RST = 10'd800;
  localparam logic [RAW_W-1:0]         LIGHT_LOW_RST  = 10'd1;
  localparam logic [RAW_W-1:0]         LIGHT_HIGH_RST = 10'd350;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_LOW   = 3'd0,
    CFG_TEMP_HIGH  = 3'd1,
    CFG_HUMID_LOW  = 3'd2,
    CFG_HUMID_HIGH = 3'd3,
    CFG_LIGHT_LOW  = 3'd4,
    CFG_LIGHT_HIGH = 3'd5
  } cfg_index_t;

endpackage

// ===== src/sav_sample_if.sv =====
interface sav_sample_if;
  import sav_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic [HUMID_W-1:0]       humid_tenths;
  logic [RAW_W-1:0]         light_raw;

  modport source (output valid, output temp_tenths, output humid_tenths, output light_raw,
                  input ready);
  modport sink   (input valid, input temp_tenths, input humid_tenths, input light_raw,
                  output ready);
endinterface

// ===== src/sav_result_if.sv =====
interface sav_result_if;
  import sav_pkg::*;

  logic               valid;
  logic               ready;
  logic [PCT_W-1:0]   light_average;
  logic               lamp_red;
  logic               lamp_yellow;
  logic               lamp_green;
  logic [TONE_W-1:0]  tone_hz;

  modport source (output valid, output light_average, output lamp_red, output lamp_yellow,
                  output lamp_green, output tone_hz, input ready);
  modport sink   (input valid, input light_average, input lamp_red, input lamp_yellow,
                  input lamp_green, input tone_hz, output ready);
endinterface

// ===== src/sensor_average_and_alarm.sv =====
// Sensor average and alarm. Each sample beat (temperature and humidity in tenths, raw
// 10-bit light) gives one result beat: the moving average over WINDOW samples of the
// light scaled to percent (raw*100/1023, truncated), the red, yellow and green lamps,
// and the buzzer tone of the last alarm that hit (temperature, then humidity, then
// light). The block takes one sample per cycle while the result side is not stalled;
// each sample passes through the input register and then the result register, and the
// ring of scaled light values is updated as the sample leaves the input register.
// Limits are written through wr_en/wr_index/wr_data; unknown indexes are ignored.
// Reset clears the ring, the sum and the ring position and loads the default limits.
module sensor_average_and_alarm #(
  parameter int WINDOW = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [sav_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [sav_pkg::CFG_DATA_W-1:0]    wr_data,
  sav_sample_if.sink                        sample,
  sav_result_if.source                      result
);
  import sav_pkg::*;

  localparam int SW = $clog2(WINDOW * PCT_SCALE + 1);
  localparam int PW = $clog2(WINDOW);
  localparam int K  = SW + $clog2(WINDOW);
  localparam longint M = ((64'd1 << K) + WINDOW - 1) / WINDOW;
  localparam int MW = $clog2(M + 1);

  // limits
  logic signed [TEMP_W-1:0] temp_low_limit, temp_high_limit;
  logic [HUMID_W-1:0]       humid_low_limit, humid_high_limit;
  logic [RAW_W-1:0]         light_low_limit, light_high_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low_limit   <= TEMP_LOW_RST;
      temp_high_limit  <= TEMP_HIGH_RST;
      humid_low_limit  <= HUMID_LOW_RST;
      humid_high_limit <= HUMID_HIGH_RST;
      light_low_limit  <= LIGHT_LOW_RST;
      light_high_limit <= LIGHT_HIGH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TEMP_LOW:   temp_low_limit   <= wr_data[TEMP_W-1:0];
        CFG_TEMP_HIGH:  temp_high_limit  <= wr_data[TEMP_W-1:0];
        CFG_HUMID_LOW:  humid_low_limit  <= wr_data[HUMID_W-1:0];
        CFG_HUMID_HIGH: humid_high_limit <= wr_data[HUMID_W-1:0];
        CFG_LIGHT_LOW:  light_low_limit  <= wr_data[RAW_W-1:0];
        CFG_LIGHT_HIGH: light_high_limit <= wr_data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid;
  logic out_valid;
  logic out_en;
  logic s1_move;
  logic in_take;

  assign out_en       = !out_valid || result.ready;
  assign s1_move      = s1_valid && out_en;
  assign sample.ready = !s1_valid || out_en;
  assign in_take      = sample.valid && sample.ready;

  // input register
  logic signed [TEMP_W-1:0] s1_temp;
  logic [HUMID_W-1:0]       s1_humid;
  logic [RAW_W-1:0]         s1_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_temp  <= sample.temp_tenths;
      s1_humid <= sample.humid_tenths;
      s1_raw   <= sample.light_raw;
    end
  end

  // scale: x = raw*100, x/1023 = x>>10 plus one correction
  logic [SCALED_W-1:0] scaled;
  logic [PCT_W-1:0]    pct_q0;
  logic [RAW_W:0]      pct_rem;
  logic [PCT_W-1:0]    pct;

  always_comb begin
    scaled  = SCALED_W'(s1_raw) * SCALED_W'(PCT_SCALE);
    pct_q0  = scaled[SCALED_W-1:RAW_W];
    pct_rem = {1'b0, scaled[RAW_W-1:0]} + (RAW_W+1)'(pct_q0);
    pct     = pct_q0 + PCT_W'(pct_rem >= (RAW_W+1)'(RAW_FULL));
  end

  // ring
  logic [PCT_W-1:0] light_ring [WINDOW];
  logic [SW-1:0]    light_sum;
  logic [SW-1:0]    light_sum_next;
  logic [PW-1:0]    ring_position;
  logic [PW-1:0]    ring_position_next;

  always_comb begin
    light_sum_next = light_sum - SW'(light_ring[ring_position]) + SW'(pct);
    ring_position_next = (ring_position == PW'(WINDOW - 1)) ? '0 : ring_position + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) light_ring[i] <= '0;
      light_sum     <= '0;
      ring_position <= '0;
    end else if (s1_move) begin
      light_ring[ring_position] <= pct;
      light_sum     <= light_sum_next;
      ring_position <= ring_position_next;
    end
  end

  // sum / WINDOW by reciprocal
  logic [SW+MW-1:0] avg_prod;
  logic [PCT_W-1:0] avg;

  always_comb begin
    avg_prod = (SW+MW)'(light_sum_next) * (SW+MW)'(M);
    avg      = PCT_W'(avg_prod >> K);
  end

  // alarms
  logic              temp_bad, humid_bad, light_low, light_high;
  logic              red, yellow, green;
  logic [TONE_W-1:0] tone;

  always_comb begin
    temp_bad   = (s1_temp < temp_low_limit) || (s1_temp > temp_high_limit);
    humid_bad  = (s1_humid < humid_low_limit) || (s1_humid > humid_high_limit);
    light_low  = s1_raw < light_low_limit;
    light_high = !light_low && (s1_raw > light_high_limit);
    red    = temp_bad || light_high;
    yellow = humid_bad || light_low;
    green  = !light_low && !light_high;
    priority if (light_low)  tone = TONE_LIGHT_LOW;
    else if (light_high)     tone = TONE_LIGHT_HIGH;
    else if (humid_bad)      tone = TONE_HUMID;
    else if (temp_bad)       tone = TONE_TEMP;
    else                     tone = TONE_NONE;
  end

  // result register
  logic [PCT_W-1:0]  out_avg;
  logic              out_red, out_yellow, out_green;
  logic [TONE_W-1:0] out_tone;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_avg    <= avg;
      out_red    <= red;
      out_yellow <= yellow;
      out_green  <= green;
      out_tone   <= tone;
    end
  end

  assign result.valid         = out_valid;
  assign result.light_average = out_avg;
  assign result.lamp_red      = out_red;
  assign result.lamp_yellow   = out_yellow;
  assign result.lamp_green    = out_green;
  assign result.tone_hz       = out_tone;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !result.ready) |-> !sample.ready)
    else $error("sample taken while both stages are stalled");

  a_green_no_light_tone: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.lamp_green) |->
      (result.tone_hz != TONE_LIGHT_LOW && result.tone_hz != TONE_LIGHT_HIGH))
    else $error("green lamp with a light alarm tone");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    light_sum <= SW'(WINDOW * PCT_SCALE))
    else $error("light sum beyond window maximum");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> (ring_position == $past(ring_position_next)) &&
                (ring_position <= PW'(WINDOW - 1)))
    else $error("ring position out of step");

endmodule

// ===== test/tb_sensor_average_and_alarm.sv =====
module tb_sensor_average_and_alarm;
  import sav_pkg::*;

  localparam int WINDOW       = 10;
  localparam int SETTLE       = 4;
  localparam int STALL_LIMIT  = 1000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 150;

  // indexes past the last limit register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [PCT_W-1:0]  light_average;
    logic              lamp_red;
    logic              lamp_yellow;
    logic              lamp_green;
    logic [TONE_W-1:0] tone_hz;
  } reading_t;

  typedef struct packed {
    bit       typed;
    reading_t want;
  } known_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] temp_lo;
    logic [CFG_DATA_W-1:0] temp_hi;
    logic [CFG_DATA_W-1:0] humid_lo;
    logic [CFG_DATA_W-1:0] humid_hi;
    logic [CFG_DATA_W-1:0] light_lo;
    logic [CFG_DATA_W-1:0] light_hi;
  } limits_t;

  typedef struct packed {
    logic [1:0]         preset;
    logic [TEMP_W-1:0]  temp;
    logic [HUMID_W-1:0] humid;
    logic [RAW_W-1:0]   raw;
    bit                 typed;
    reading_t           want;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  sav_sample_if smp ();
  sav_result_if res ();

  sensor_average_and_alarm #(.WINDOW(WINDOW)) uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sample   (smp),
    .result   (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [TEMP_W-1:0] lim_temp_lo  = TEMP_LOW_RST;
  logic signed [TEMP_W-1:0] lim_temp_hi  = TEMP_HIGH_RST;
  logic [HUMID_W-1:0]       lim_humid_lo = HUMID_LOW_RST;
  logic [HUMID_W-1:0]       lim_humid_hi = HUMID_HIGH_RST;
  logic [RAW_W-1:0]         lim_light_lo = LIGHT_LOW_RST;
  logic [RAW_W-1:0]         lim_light_hi = LIGHT_HIGH_RST;
  logic [PCT_W-1:0]         light_ring [WINDOW] = '{default: '0};
  int unsigned              light_sum = 0;
  int unsigned              ring_pos = 0;

  reading_t    pending_readings [$];
  known_t      known_q [$];
  probe_t      probes [$];
  limits_t     presets [4];
  bit          no_idle = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned samples_seen = 0;
  int unsigned results_checked = 0;
  int unsigned limit_loads = 0;

  function automatic reading_t judge_sample(logic signed [TEMP_W-1:0] temp,
                                            logic [HUMID_W-1:0] humid,
                                            logic [RAW_W-1:0] raw);
    reading_t    r;
    int unsigned scaled;
    scaled = raw;
    scaled = scaled * PCT_SCALE / RAW_FULL;
    light_sum = light_sum - light_ring[ring_pos] + scaled;
    light_ring[ring_pos] = scaled[PCT_W-1:0];
    ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
    r = '0;
    r.light_average = PCT_W'(light_sum / WINDOW);
    r.tone_hz = TONE_NONE;
    if (temp < lim_temp_lo || temp > lim_temp_hi) begin
      r.lamp_red = 1'b1;
      r.tone_hz = TONE_TEMP;
    end
    if (humid < lim_humid_lo || humid > lim_humid_hi) begin
      r.lamp_yellow = 1'b1;
      r.tone_hz = TONE_HUMID;
    end
    // low light wins over high light when the limits are crossed
    if (raw < lim_light_lo) begin
      r.lamp_yellow = 1'b1;
      r.tone_hz = TONE_LIGHT_LOW;
    end else if (raw > lim_light_hi) begin
      r.lamp_red = 1'b1;
      r.tone_hz = TONE_LIGHT_HIGH;
    end else begin
      r.lamp_green = 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TEMP_W-1:0] pick_temp();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return TEMP_W'($urandom);
    if (r < 4) return lim_temp_lo + TEMP_W'($urandom_range(0, 2)) - 11'd1;
    if (r < 6) return lim_temp_hi + TEMP_W'($urandom_range(0, 2)) - 11'd1;
    return TEMP_W'(int'($urandom_range(0, 1200)) - 400);
  endfunction

  function automatic logic [HUMID_W-1:0] pick_humid();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return HUMID_W'($urandom);
    if (r < 4) return lim_humid_lo + HUMID_W'($urandom_range(0, 2)) - 10'd1;
    if (r < 6) return lim_humid_hi + HUMID_W'($urandom_range(0, 2)) - 10'd1;
    return HUMID_W'($urandom_range(0, 1000));
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return lim_light_lo + RAW_W'($urandom_range(0, 2)) - 10'd1;
    if (r < 4) return lim_light_hi + RAW_W'($urandom_range(0, 2)) - 10'd1;
    if (r < 5) return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    return RAW_W'($urandom);
  endfunction

  function automatic limits_t draw_limits(bit wild);
    limits_t l;
    if (wild) begin
      l.temp_lo  = CFG_DATA_W'($urandom);
      l.temp_hi  = CFG_DATA_W'($urandom);
      l.humid_lo = CFG_DATA_W'($urandom);
      l.humid_hi = CFG_DATA_W'($urandom);
      l.light_lo = CFG_DATA_W'($urandom);
      l.light_hi = CFG_DATA_W'($urandom);
    end else begin
      l.temp_lo  = CFG_DATA_W'(int'($urandom_range(0, 800)) - 400);
      l.temp_hi  = CFG_DATA_W'(int'($urandom_range(300, 1200)) - 400);
      l.humid_lo = CFG_DATA_W'($urandom_range(0, 700));
      l.humid_hi = CFG_DATA_W'($urandom_range(300, 1000));
      l.light_lo = CFG_DATA_W'($urandom_range(0, 600));
      l.light_hi = CFG_DATA_W'($urandom_range(200, 1023));
    end
    return l;
  endfunction

  task automatic send_sample(input logic [TEMP_W-1:0] t, input logic [HUMID_W-1:0] h,
                             input logic [RAW_W-1:0] l, input known_t k);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    known_q.push_back(k);
    smp.valid        <= 1'b1;
    smp.temp_tenths  <= t;
    smp.humid_tenths <= h;
    smp.light_raw    <= l;
    do @(posedge clk); while (!smp.ready);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_limits(input limits_t lim);
    wr_en    <= 1'b1;
    wr_index <= CFG_TEMP_LOW;
    wr_data  <= lim.temp_lo;
    @(posedge clk);
    wr_index <= CFG_TEMP_HIGH;
    wr_data  <= lim.temp_hi;
    @(posedge clk);
    wr_index <= CFG_HUMID_LOW;
    wr_data  <= lim.humid_lo;
    @(posedge clk);
    wr_index <= CFG_HUMID_HIGH;
    wr_data  <= lim.humid_hi;
    @(posedge clk);
    wr_index <= CFG_LIGHT_LOW;
    wr_data  <= lim.light_lo;
    @(posedge clk);
    wr_index <= CFG_LIGHT_HIGH;
    wr_data  <= lim.light_hi;
    @(posedge clk);
    wr_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
    wr_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    wr_en <= 1'b0;
    limit_loads++;
  endtask

  // result sink with random back-pressure
  initial begin
    forever begin
      int unsigned stall;
      res.ready <= 1'b1;
      repeat (1 + $urandom_range(0, 7)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : monitor
    reading_t got;
    reading_t want;
    known_t   k;
    bit       quiet;
    if (!rst) begin
      quiet = 1'b1;
      if (wr_en) begin
        quiet = 1'b0;
        case (wr_index)
          CFG_TEMP_LOW:   lim_temp_lo  = wr_data;
          CFG_TEMP_HIGH:  lim_temp_hi  = wr_data;
          CFG_HUMID_LOW:  lim_humid_lo = wr_data[HUMID_W-1:0];
          CFG_HUMID_HIGH: lim_humid_hi = wr_data[HUMID_W-1:0];
          CFG_LIGHT_LOW:  lim_light_lo = wr_data[RAW_W-1:0];
          CFG_LIGHT_HIGH: lim_light_hi = wr_data[RAW_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        quiet = 1'b0;
        got.light_average = res.light_average;
        got.lamp_red      = res.lamp_red;
        got.lamp_yellow   = res.lamp_yellow;
        got.lamp_green    = res.lamp_green;
        got.tone_hz       = res.tone_hz;
        if (pending_readings.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          results_checked++;
          if (got.light_average !== want.light_average) begin
            $error("light_average: expected %0d, got %0d", want.light_average,
                   got.light_average);
            mismatches++;
          end
          if (got.lamp_red !== want.lamp_red) begin
            $error("lamp_red: expected %0d, got %0d", want.lamp_red, got.lamp_red);
            mismatches++;
          end
          if (got.lamp_yellow !== want.lamp_yellow) begin
            $error("lamp_yellow: expected %0d, got %0d", want.lamp_yellow, got.lamp_yellow);
            mismatches++;
          end
          if (got.lamp_green !== want.lamp_green) begin
            $error("lamp_green: expected %0d, got %0d", want.lamp_green, got.lamp_green);
            mismatches++;
          end
          if (got.tone_hz !== want.tone_hz) begin
            $error("tone_hz: expected %0d, got %0d", want.tone_hz, got.tone_hz);
            mismatches++;
          end
        end
      end
      if (smp.valid && smp.ready) begin
        quiet = 1'b0;
        samples_seen++;
        want = judge_sample(smp.temp_tenths, smp.humid_tenths, smp.light_raw);
        if (known_q.size() != 0) begin
          k = known_q.pop_front();
          if (k.typed) want = k.want;
        end
        pending_readings.push_back(want);
      end
      idle_cycles = quiet ? idle_cycles + 1 : 0;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("** sensor_average_and_alarm: FAILED **");
    $finish;
  end

  initial begin
    logic [1:0] cur_sel;
    limits_t    lim;

    rst              <= 1'b1;
    wr_en            <= 1'b0;
    wr_index         <= CFG_TEMP_LOW;
    wr_data          <= '0;
    smp.valid        <= 1'b0;
    smp.temp_tenths  <= '0;
    smp.humid_tenths <= '0;
    smp.light_raw    <= '0;

    presets[0] = '{TEMP_LOW_RST, TEMP_HIGH_RST, HUMID_LOW_RST, HUMID_HIGH_RST,
                   LIGHT_LOW_RST, LIGHT_HIGH_RST};
    presets[1] = '{11'sd300, -11'sd300, 11'd900, 11'd100, 11'd500, 11'd100};
    presets[2] = '{-11'sd400, 11'sd800, 11'd0, 11'd1000, 11'd0, 11'd1023};
    presets[3] = '{11'sd800, -11'sd400, 11'd1000, 11'd0, 11'd1023, 11'd0};

    // reset limits, fresh ring
    probes.push_back('{2'd0, 11'sd100, 10'd700, 10'd0, 1'b1,
                       '{7'd0, 1'b0, 1'b1, 1'b0, TONE_LIGHT_LOW}});
    probes.push_back('{2'd0, 11'sd100, 10'd700, 10'd1023, 1'b1,
                       '{7'd10, 1'b1, 1'b0, 1'b0, TONE_LIGHT_HIGH}});
    probes.push_back('{2'd0, -11'sd400, 10'd700, 10'd200, 1'b1,
                       '{7'd11, 1'b1, 1'b0, 1'b1, TONE_TEMP}});
    probes.push_back('{2'd0, 11'sd800, 10'd0, 10'd350, 1'b1,
                       '{7'd15, 1'b1, 1'b1, 1'b1, TONE_HUMID}});
    probes.push_back('{2'd0, 11'sd60, 10'd1000, 10'd1, 1'b0, '0});
    probes.push_back('{2'd0, 11'sd200, 10'd600, 10'd351, 1'b0, '0});
    probes.push_back('{2'd0, 11'sd201, 10'd800, 10'd100, 1'b0, '0});
    probes.push_back('{2'd0, 11'sd59, 10'd801, 10'd0, 1'b0, '0});
    probes.push_back('{2'd0, 11'sd100, 10'd599, 10'd1023, 1'b0, '0});
    probes.push_back('{2'd0, 11'sd100, 10'd700, 10'd500, 1'b0, '0});
    probes.push_back('{2'd0, 11'sd100, 10'd700, 10'd1023, 1'b0, '0});
    // raw patterns outside the documented ranges
    probes.push_back('{2'd0, 11'h3ff, 10'h3ff, 10'd512, 1'b0, '0});
    probes.push_back('{2'd0, 11'h400, 10'd1001, 10'd0, 1'b0, '0});
    probes.push_back('{2'd0, 11'h7ff, 10'd700, 10'd1022, 1'b0, '0});
    // crossed limits
    probes.push_back('{2'd1, 11'sd0, 10'd500, 10'd300, 1'b0, '0});
    probes.push_back('{2'd1, 11'sd0, 10'd500, 10'd600, 1'b0, '0});
    probes.push_back('{2'd1, -11'sd350, 10'd50, 10'd100, 1'b0, '0});
    // widest limits
    probes.push_back('{2'd2, -11'sd400, 10'd0, 10'd0, 1'b0, '0});
    probes.push_back('{2'd2, 11'sd800, 10'd1000, 10'd1023, 1'b0, '0});
    probes.push_back('{2'd2, 11'h400, 10'h3ff, 10'd512, 1'b0, '0});
    // fully closed limits
    probes.push_back('{2'd3, 11'sd100, 10'd500, 10'd1023, 1'b0, '0});
    probes.push_back('{2'd3, 11'sd100, 10'd500, 10'd1022, 1'b0, '0});
    probes.push_back('{2'd3, 11'sd800, 10'd1000, 10'd0, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_sel = 2'd0;
    foreach (probes[i]) begin
      if (probes[i].preset != cur_sel) begin
        drain();
        load_limits(presets[probes[i].preset]);
        cur_sel = probes[i].preset;
      end
      send_sample(probes[i].temp, probes[i].humid, probes[i].raw,
                  '{probes[i].typed, probes[i].want});
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0:       lim = presets[0];
        3:       lim = presets[2];
        5:       lim = presets[1];
        6, 7:    lim = draw_limits(1'b1);
        default: lim = draw_limits(1'b0);
      endcase
      load_limits(lim);
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) drain();
        send_sample(pick_temp(), pick_humid(), pick_raw(), '0);
      end
    end
    no_idle = 1'b0;
    drain();

    $display("covered %0d sample beats and %0d result beats over %0d limit loads,",
             samples_seen, results_checked, limit_loads);
    $display("including crossed, widest and closed limits and spare register writes");
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("** sensor_average_and_alarm: PASSED **");
    end else begin
      $display("** sensor_average_and_alarm: FAILED **");
    end
    $finish;
  end

endmodule
